// ===== hdl/cqf_pkg.sv =====
// ---------------------------------------------------------------------------
// cqf_pkg
// Shared widths, operation and status codes, and the control/status structs
// passed between the circular queue controller and datapath.
// ---------------------------------------------------------------------------
package cqf_pkg;

   localparam int DEPTH_DEF = 8;
   localparam int DATA_W    = 32;
   localparam int SLOT_W    = 6;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;

   localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DUMP = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic enq;        // store the word at the tail
      logic refuse;     // enqueue refused, queue full
      logic empty;      // read request on empty queue
      logic rd_start;   // first read of a dequeue, peek or dump
      logic pop;        // rd_start is a dequeue
      logic multi;      // rd_start is a dump
      logic rd_next;    // next read of a running dump
      logic rd_active;  // RAM read data is the current result
   } cqf_cmd_type;

   typedef struct packed {
      logic holds;
      logic full;
      logic rd_final;
   } cqf_stat_type;

endpackage

// ===== hdl/circular_queue_fifo.sv =====
// ---------------------------------------------------------------------------
// circular_queue_fifo
// Fixed-depth circular FIFO of signed words: enqueue, dequeue, peek, dump.
// ---------------------------------------------------------------------------
// The first result of an item appears in the cycle after it is accepted.
// Enqueue, dequeue, peek and error answers: one item per cycle.
// Dump of N stored words: N results, one per RAM read; busy holds off
//   new items until the cycle of the last result.
// Reset: synchronous; queue empty, pointers zero, storage left unwritten.
// Results cannot be stalled by the receiver.
module circular_queue_fifo #(
   parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cqf_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [cqf_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   output logic signed [cqf_pkg::DATA_W-1:0]   rsp_data,
   output logic [cqf_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [cqf_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_last
);
   import cqf_pkg::*;

   cqf_cmd_type  cmd;
   cqf_stat_type stat;

   cqf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_kind),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   cqf_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value      (req_value),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== hdl/cqf_ram.sv =====
// ---------------------------------------------------------------------------
// cqf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cqf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cqf_ctrl.sv =====
// ---------------------------------------------------------------------------
// cqf_ctrl
// Queue controller: decodes accepted items into datapath commands and walks
// the read phase of dequeue, peek and dump.
// ---------------------------------------------------------------------------
module cqf_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cqf_pkg::KIND_W-1:0]  kind,
   input  cqf_pkg::cqf_stat_type       stat,
   output logic                        busy,
   output cqf_pkg::cqf_cmd_type        cmd
);
   import cqf_pkg::*;

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_READ = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;
   logic       accept;
   logic       is_enq;

   always_comb begin
      busy   = (state_ff == ST_READ) && !stat.rd_final;
      accept = start && !busy;
      is_enq = (kind == KIND_ENQ);

      cmd.enq       = accept && is_enq && !stat.full;
      cmd.refuse    = accept && is_enq && stat.full;
      cmd.empty     = accept && !is_enq && !stat.holds;
      cmd.rd_start  = accept && !is_enq && stat.holds;
      cmd.pop       = (kind == KIND_DEQ);
      cmd.multi     = (kind == KIND_DUMP);
      cmd.rd_active = (state_ff == ST_READ);
      cmd.rd_next   = (state_ff == ST_READ) && !stat.rd_final;

      unique case (state_ff)
         ST_IDLE: begin
            state_in = cmd.rd_start ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = (cmd.rd_start || cmd.rd_next) ? ST_READ : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/cqf_dp.sv =====
// ---------------------------------------------------------------------------
// cqf_dp
// Queue datapath: head/tail pointers, storage RAM, read index for dequeue,
// peek and dump, and the result registers.
// ---------------------------------------------------------------------------
module cqf_dp #(
   parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cqf_pkg::cqf_cmd_type                cmd,
   input  logic signed [cqf_pkg::DATA_W-1:0]   value,
   output cqf_pkg::cqf_stat_type               stat,
   output logic                                rsp_valid,
   output logic signed [cqf_pkg::DATA_W-1:0]   rsp_data,
   output logic [cqf_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [cqf_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_last
);
   import cqf_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(DEPTH - 1)) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   logic [IDX_W-1:0]           head_ff, tail_ff, rd_idx_ff;
   logic                       holds_ff, multi_ff;
   logic                       imm_valid_ff;
   logic signed [DATA_W-1:0]   imm_data_ff;
   logic [IDX_W-1:0]           imm_slot_ff;
   logic [STATUS_W-1:0]        imm_status_ff;

   logic [IDX_W-1:0]           wr_addr, rd_addr, tail_next;
   logic [DATA_W-1:0]          ram_q;

   always_comb begin
      tail_next     = next_idx(tail_ff);
      stat.holds    = holds_ff;
      stat.full     = holds_ff && (tail_next == head_ff);
      stat.rd_final = !multi_ff || (rd_idx_ff == tail_ff);
      wr_addr       = holds_ff ? tail_next : '0;
      rd_addr       = cmd.rd_next ? next_idx(rd_idx_ff) : head_ff;
   end

   cqf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.enq),
      .wr_addr (wr_addr),
      .wr_data (value),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         holds_ff     <= 1'b0;
         multi_ff     <= 1'b0;
         imm_valid_ff <= 1'b0;
      end else begin
         if (cmd.enq) begin
            holds_ff <= 1'b1;
            head_ff  <= holds_ff ? head_ff : '0;
            tail_ff  <= wr_addr;
         end else if (cmd.rd_start && cmd.pop) begin
            if (head_ff == tail_ff) begin
               head_ff  <= '0;
               tail_ff  <= '0;
               holds_ff <= 1'b0;
            end else begin
               head_ff <= next_idx(head_ff);
            end
         end
         if (cmd.rd_start) begin
            multi_ff <= cmd.multi;
         end
         imm_valid_ff <= cmd.enq || cmd.refuse || cmd.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_start || cmd.rd_next) begin
         rd_idx_ff <= rd_addr;
      end
      imm_data_ff <= cmd.enq ? value : '0;
      imm_slot_ff <= cmd.enq ? wr_addr : '0;
      priority if (cmd.refuse) begin
         imm_status_ff <= STAT_FULL;
      end else if (cmd.empty) begin
         imm_status_ff <= STAT_EMPTY;
      end else begin
         imm_status_ff <= STAT_OK;
      end
   end

   always_comb begin
      rsp_valid  = imm_valid_ff || cmd.rd_active;
      rsp_data   = cmd.rd_active ? ram_q : imm_data_ff;
      rsp_slot   = cmd.rd_active ? SLOT_W'(rd_idx_ff) : SLOT_W'(imm_slot_ff);
      rsp_status = cmd.rd_active ? STAT_OK : imm_status_ff;
      rsp_last   = cmd.rd_active ? stat.rd_final : 1'b1;
   end

endmodule

// ===== hdl/cqf_checker.sv =====
// ---------------------------------------------------------------------------
// cqf_checker
// Port-level checks of the circular queue, bound to the top level.
// ---------------------------------------------------------------------------
module cqf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [cqf_pkg::KIND_W-1:0]          req_kind,
   input logic signed [cqf_pkg::DATA_W-1:0]   req_value,
   input logic                                rsp_valid,
   input logic signed [cqf_pkg::DATA_W-1:0]   rsp_data,
   input logic [cqf_pkg::SLOT_W-1:0]          rsp_slot,
   input logic [cqf_pkg::STATUS_W-1:0]        rsp_status,
   input logic                                rsp_last
);
   import cqf_pkg::*;

   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted item gave no result in the next cycle");

   a_busy_mid_dump: assert property (@(posedge clock) disable iff (reset)
      busy |-> (rsp_valid && !rsp_last))
      else $error("busy without a running dump");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy ##1 rsp_valid)
      else $error("dump ended without a last result");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_last && rsp_data == '0 && rsp_slot == '0))
      else $error("error result not single, zero data and slot");

   a_enq_echo: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_ENQ) |=>
         (rsp_status == STAT_FULL || rsp_data == $past(req_value)))
      else $error("enqueue result does not echo the stored word");

endmodule

bind circular_queue_fifo cqf_checker u_cqf_checker (.*);
